[design/esd_pkg.sv]
// Shared types, character codes and helpers for the escape sequence decoder.
package esd_pkg;

  // Default width of one decoded code unit.
  localparam int CODE_WIDTH_DEF = 16;

  // Width of the collected hex value; a run holds at most four digits.
  localparam int HEX_W = 16;

  // Character codes that steer the decoder.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Digit counts that close a run.
  localparam logic [2:0] X_DIGITS = 3'd2;
  localparam logic [2:0] U_DIGITS = 3'd4;

  typedef enum logic [3:0] {
    M_PLAIN = 4'b0001,
    M_ESC   = 4'b0010,
    M_HEXX  = 4'b0100,
    M_HEXU  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] val;
  } nibble_t;

  // Decodes one ASCII hex digit of either case.
  function automatic nibble_t nibble_of(input logic [7:0] b);
    nibble_t r;
    r.is_hex = 1'b0;
    r.val    = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.is_hex = 1'b1;
      r.val    = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.is_hex = 1'b1;
      r.val    = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.is_hex = 1'b1;
      r.val    = 4'(b - 8'h37);
    end
    return r;
  endfunction

endpackage

[design/escape_sequence_decoder_core.sv]
// Top level of the backslash escape decoder: decode logic and result queue.
//
// Usage: the string enters one byte per request on the input channel
// (in_valid / in_ready, with in_byte and in_last marking the final byte).
// Decoded code units leave on the output channel (out_valid / out_ready,
// with code_unit and out_last marking the final unit of the string).
// Each accepted byte is decoded in the cycle it is accepted and gives zero,
// one or two results, which are written into a four-entry result queue.
// A result is presented the cycle after its byte is accepted when the queue
// is empty. Throughput is one byte per cycle while in_ready is high;
// in_ready depends only on the queue fill and stays high while at least two
// entries are free, so a byte that closes a hex run with a second result
// does not hold up the input unless the receiver stalls.
// When the receiver holds out_ready low, results collect in the queue and
// in_ready drops once fewer than two entries remain free; nothing is lost.
// Synchronous reset empties the queue and returns the decoder to plain text
// with no hex run in progress; the next byte starts a new string.
module escape_sequence_decoder_core
  import esd_pkg::*;
#(
  parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_WIDTH-1:0] code_unit,
  output logic                  out_last
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Decoder state.
  mode_t             mode, mode_next;
  logic [HEX_W-1:0]  hex_value, hex_value_next;
  logic [2:0]        digit_count, digit_count_next;

  // Results of the byte being accepted.
  logic [1:0]            n_res;
  logic [CODE_WIDTH-1:0] r0_unit, r1_unit;
  logic                  r0_last, r1_last;

  // Result queue.
  logic [CODE_WIDTH-1:0] q_unit [QDEPTH];
  logic                  q_last [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]     count;

  logic in_acc, out_acc;
  nibble_t nib;
  logic [HEX_W-1:0] hex_shift;
  logic [2:0] cnt_inc;
  logic [CODE_WIDTH-1:0] byte_unit;

  // Room for two results is kept free whenever a byte may enter.
  assign in_ready  = (count <= QCNT_W'(QDEPTH - 2));
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_acc   = out_valid && out_ready;
  assign code_unit = q_unit[rd_ptr];
  assign out_last  = q_last[rd_ptr];

  assign nib       = nibble_of(in_byte);
  assign hex_shift = {hex_value[HEX_W-5:0], nib.val};
  assign cnt_inc   = digit_count + 3'd1;
  assign byte_unit = CODE_WIDTH'(in_byte);

  always_comb begin
    mode_next        = mode;
    hex_value_next   = hex_value;
    digit_count_next = digit_count;
    n_res            = 2'd0;
    r0_unit          = byte_unit;
    r0_last          = in_last;
    r1_unit          = byte_unit;
    r1_last          = in_last;
    unique case (mode)
      M_PLAIN: begin
        if (in_byte == CH_BSLASH && !in_last) begin
          mode_next = M_ESC;
        end else begin
          n_res = 2'd1;
        end
      end
      M_ESC: begin
        mode_next = M_PLAIN;
        n_res     = 2'd1;
        if (in_byte == CH_N) begin
          r0_unit = CODE_WIDTH'(CH_LF);
        end else if (in_byte == CH_R) begin
          r0_unit = CODE_WIDTH'(CH_CR);
        end else if (in_byte == CH_T) begin
          r0_unit = CODE_WIDTH'(CH_TAB);
        end else if (in_byte == CH_X || in_byte == CH_U) begin
          hex_value_next   = '0;
          digit_count_next = 3'd0;
          if (!in_last) begin
            n_res     = 2'd0;
            mode_next = (in_byte == CH_X) ? M_HEXX : M_HEXU;
          end
        end
      end
      M_HEXX, M_HEXU: begin
        if (nib.is_hex) begin
          hex_value_next   = hex_shift;
          digit_count_next = cnt_inc;
          if (cnt_inc >= ((mode == M_HEXX) ? X_DIGITS : U_DIGITS)) begin
            n_res   = 2'd1;
            r0_unit = CODE_WIDTH'(hex_shift);
          end else if (in_last) begin
            n_res   = 2'd1;
            r0_unit = (mode == M_HEXX) ? CODE_WIDTH'(hex_shift) : CODE_WIDTH'(CH_U);
          end
          if (n_res != 2'd0) begin
            mode_next        = M_PLAIN;
            hex_value_next   = '0;
            digit_count_next = 3'd0;
          end
        end else begin
          // A non-hex byte closes the run, then is taken as plain text.
          hex_value_next   = '0;
          digit_count_next = 3'd0;
          r0_last          = 1'b0;
          if (mode == M_HEXU) begin
            r0_unit = CODE_WIDTH'(CH_U);
          end else if (digit_count != 3'd0) begin
            r0_unit = CODE_WIDTH'(hex_value);
          end else begin
            r0_unit = CODE_WIDTH'(CH_X);
          end
          if (in_byte == CH_BSLASH && !in_last) begin
            mode_next = M_ESC;
            n_res     = 2'd1;
          end else begin
            mode_next = M_PLAIN;
            n_res     = 2'd2;
          end
        end
      end
      default: begin
        mode_next = M_PLAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_PLAIN;
      hex_value   <= '0;
      digit_count <= 3'd0;
    end else if (in_acc) begin
      mode        <= mode_next;
      hex_value   <= hex_value_next;
      digit_count <= digit_count_next;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      q_unit[wr_ptr] <= r0_unit;
      q_last[wr_ptr] <= r0_last;
    end
    if (in_acc && n_res == 2'd2) begin
      q_unit[wr_ptr + QPTR_W'(1)] <= r1_unit;
      q_last[wr_ptr + QPTR_W'(1)] <= r1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + QPTR_W'(n_res);
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (in_acc ? QCNT_W'(n_res) : QCNT_W'(0))
                     - (out_acc ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the escape sequence decoder core.
module tb
  import esd_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX = 10;

  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";
  localparam logic [7:0] CH_LA = "a";
  localparam logic [7:0] CH_LF_HEX = "f";
  localparam logic [7:0] CH_UA = "A";
  localparam logic [7:0] CH_UF = "F";

  typedef struct {
    logic [15:0] unit;
    logic        last;
  } dec_unit_t;

  // Scoreboard: tracks the decoder state and the code units still owed.
  class esd_scoreboard;
    mode_t       mode;
    logic [15:0] hex_acc;
    logic [2:0]  ndig;
    dec_unit_t   owed_units[$];
    int          errors;

    function new();
      mode    = M_PLAIN;
      hex_acc = '0;
      ndig    = '0;
      errors  = 0;
    endfunction

    function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v = 4'(c - CH_ZERO);
        return 1'b1;
      end
      if (c >= CH_LA && c <= CH_LF_HEX) begin
        v = 4'(c - CH_LA + 8'd10);
        return 1'b1;
      end
      if (c >= CH_UA && c <= CH_UF) begin
        v = 4'(c - CH_UA + 8'd10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void owe(logic [15:0] u, logic l);
      dec_unit_t e;
      e.unit = u;
      e.last = l;
      owed_units.insert(owed_units.size(), e);
    endfunction

    function void clear_run();
      hex_acc = '0;
      ndig    = '0;
    endfunction

    // A backslash that is not the last byte opens an escape.
    function void take_plain(logic [7:0] b, logic l);
      if (b == CH_BSLASH && !l) begin
        mode = M_ESC;
      end else begin
        mode = M_PLAIN;
        owe(16'(b), l);
      end
    endfunction

    function void note_request(logic [7:0] b, logic l);
      logic [3:0] dv;
      bit         is_dig;
      is_dig = hex_digit(b, dv);
      case (mode)
        M_ESC: begin
          mode = M_PLAIN;
          if (b == CH_N) begin
            owe(16'(CH_LF), l);
          end else if (b == CH_R) begin
            owe(16'(CH_CR), l);
          end else if (b == CH_T) begin
            owe(16'(CH_TAB), l);
          end else if (b == CH_X || b == CH_U) begin
            clear_run();
            if (l) owe(16'(b), 1'b1);
            else mode = (b == CH_X) ? M_HEXX : M_HEXU;
          end else begin
            owe(16'(b), l);
          end
        end
        M_HEXX: begin
          if (is_dig) begin
            hex_acc = {hex_acc[11:0], dv};
            ndig    = ndig + 3'd1;
            if (ndig >= X_DIGITS || l) begin
              owe(hex_acc, l);
              mode = M_PLAIN;
              clear_run();
            end
          end else begin
            // A run without digits falls back to a literal x.
            owe((ndig != 0) ? hex_acc : 16'(CH_X), 1'b0);
            clear_run();
            take_plain(b, l);
          end
        end
        M_HEXU: begin
          if (is_dig) begin
            hex_acc = {hex_acc[11:0], dv};
            ndig    = ndig + 3'd1;
            if (ndig >= U_DIGITS) begin
              owe(hex_acc, l);
              mode = M_PLAIN;
              clear_run();
            end else if (l) begin
              owe(16'(CH_U), 1'b1);
              mode = M_PLAIN;
              clear_run();
            end
          end else begin
            owe(16'(CH_U), 1'b0);
            clear_run();
            take_plain(b, l);
          end
        end
        default: take_plain(b, l);
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_result(logic [15:0] u, logic l);
      dec_unit_t e;
      if (owed_units.size() == 0) begin
        report($sformatf("unexpected code unit %h last %b", u, l));
        return;
      end
      e = owed_units.pop_front();
      if (u !== e.unit)
        report($sformatf("code unit expected %h, got %h", e.unit, u));
      if (l !== e.last)
        report($sformatf("last flag expected %b, got %b (code %h)", e.last, l, u));
    endfunction

    function int owed();
      return owed_units.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        out_last;

  int            send_idle_pct = 15;
  int            recv_idle_pct = 53;
  int            cycles = 0;
  esd_scoreboard sb;

  escape_sequence_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .out_last  (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(code_unit, out_last);
  end

  // Entered just after a rising edge; returns at the edge that accepts the request.
  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(b, l);
  endtask

  task automatic send_string(input logic [7:0] text[$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(v - 10);
  endfunction

  // Adds one byte at the end of a string under construction.
  function automatic void append_char(ref logic [7:0] text[$], input logic [7:0] c);
    text.insert(text.size(), c);
  endfunction

  // Mostly well-formed escapes with random content, with some raw noise.
  task automatic make_string(ref logic [7:0] text[$]);
    int         nseg;
    int         kind;
    logic [7:0] b;
    text.delete();
    nseg = $urandom_range(1, 8);
    repeat (nseg) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        do b = any_byte(); while (b == CH_BSLASH);
        append_char(text, b);
      end else if (kind < 40) begin
        append_char(text, CH_BSLASH);
        case ($urandom_range(3))
          0: append_char(text, CH_N);
          1: append_char(text, CH_R);
          2: append_char(text, CH_T);
          default: append_char(text, CH_BSLASH);
        endcase
      end else if (kind < 60) begin
        append_char(text, CH_BSLASH);
        append_char(text, CH_X);
        repeat ($urandom_range(0, 2)) append_char(text, hex_char());
      end else if (kind < 80) begin
        append_char(text, CH_BSLASH);
        append_char(text, CH_U);
        repeat ($urandom_range(0, 4)) append_char(text, hex_char());
      end else if (kind < 88) begin
        append_char(text, CH_BSLASH);
        append_char(text, any_byte());
      end else begin
        append_char(text, any_byte());
      end
    end
    if ($urandom_range(9) == 0) append_char(text, CH_BSLASH);
  endtask

  initial begin
    logic [7:0] text[$];
    int         sent;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: every simple escape, an unknown escape of the top byte,
    // two-digit and one-digit x runs, a run closed by a non-hex byte, a full
    // u run ended by a trailing backslash, and an x run cut by the last byte.
    send_string('{8'h01, CH_BSLASH, CH_N, CH_BSLASH, CH_R, CH_BSLASH, CH_T,
                  CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'hFF, CH_BSLASH, CH_X, "A", "f",
                  CH_BSLASH, CH_X, "5", "Z"});
    send_string('{CH_BSLASH, CH_U, "0", "e", "9", "F", CH_BSLASH});
    send_string('{CH_BSLASH, CH_X, "7"});

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 53;
        end
        1: begin
          send_idle_pct = 53;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        make_string(text);
        send_string(text);
        sent += text.size();
      end
    end
    in_valid <= 1'b0;

    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
